// ----- hdl/nlej_pkg.sv -----
// Package for the nested-loop equi-join unit: sizes, row types, command and
// register codes, and the request bundle that drives the row store.
// No dependencies; every other file in hdl/ uses it by scoped names.
package nlej_pkg;

    // Store capacity in rows, and columns of the joined row that are kept.
    localparam int MAX_ROWS = 16;
    localparam int MAX_COLS = 10;

    // Columns carried by an input row and by a joined output row.
    localparam int IN_COLS  = 9;
    localparam int OUT_COLS = 10;
    localparam int COL_W    = 32;

    // Row address and fill count widths follow from the capacity.
    localparam int ROW_IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);

    // Configuration port geometry.
    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 2;

    typedef logic signed [COL_W-1:0] t_col;
    typedef t_col [IN_COLS-1:0]      t_row;
    typedef t_col [OUT_COLS-1:0]     t_out_row;
    typedef logic [ROW_IDX_W-1:0]    t_row_idx;
    typedef logic [ROW_CNT_W-1:0]    t_row_cnt;
    typedef logic [CFG_DATA_W-1:0]   t_cfg;

    // Item kinds carried in the input tuser.
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_PROBE = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTER_WIDTH = 2'd0,
        CFG_INNER_WIDTH = 2'd1,
        CFG_OUTER_KEY   = 2'd2,
        CFG_INNER_KEY   = 2'd3
    } t_cfg_idx;

    // One write port and one read port of the row store.
    typedef struct packed {
        logic     wr_en;
        t_row_idx wr_addr;
        logic     rd_en;
        t_row_idx rd_addr;
    } t_store_req;

endpackage

// ----- hdl/nlej_row_store.sv -----
// Row store of the join unit: one stored row per entry, written whole on a
// load and read whole during a probe scan, with registered read data.
// Depends on nlej_pkg.
module nlej_row_store (
    input  logic                i_clk,
    input  nlej_pkg::t_store_req i_req,
    input  nlej_pkg::t_row      i_wr_row,
    output nlej_pkg::t_row      o_rd_row
);

    nlej_pkg::t_row mem [nlej_pkg::MAX_ROWS];
    nlej_pkg::t_row r_rd_row;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_wr_row;
        end
    end

    // Read port; the data register holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_row <= mem[i_req.rd_addr];
        end
    end

    assign o_rd_row = r_rd_row;

endmodule

// ----- hdl/nested_loop_equi_join_unit.sv -----
// Top level of the nested-loop equi-join unit: command decode, probe scan
// sequencer, pending-match and output registers. Depends on nlej_pkg and
// instantiates nlej_row_store.
//
// Load, clear and no-op items leave the unit ready for the next item; a load
// into a full store first hands over its overflow result. A probe walks the
// stored rows in load order through the single read port of the row store,
// one row per cycle while no match waits for a stalled output. No new item is
// taken until the scan and flush of a probe are done. Each match is held back
// one step so that the last one can carry tlast; a probe without matches gives
// no result.
module nested_loop_equi_join_unit (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // Configuration write port.
    input  logic                                      i_cfg_we,
    input  logic [nlej_pkg::CFG_IDX_W-1:0]            i_cfg_idx,
    input  logic [nlej_pkg::CFG_DATA_W-1:0]           i_cfg_data,
    // Input items.
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // tdata: in_col0 .. in_col8, 32 bits each, from the lowest bit up.
    input  logic [nlej_pkg::IN_COLS*nlej_pkg::COL_W-1:0]  s_axis_tdata,
    // tuser: cmd.
    input  logic [1:0]                                s_axis_tuser,
    // Result items.
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // tdata: out_col0 .. out_col9, 32 bits each, from the lowest bit up.
    output logic [nlej_pkg::OUT_COLS*nlej_pkg::COL_W-1:0] m_axis_tdata,
    // tlast: last_match.
    output logic                                      m_axis_tlast,
    // tuser: overflow.
    output logic [0:0]                                m_axis_tuser
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_FLUSH = 4'b0100,
        S_OVF   = 4'b1000
    } t_state;

    // Column count clamped to what a row can hold.
    function automatic nlej_pkg::t_cfg eff_width(input nlej_pkg::t_cfg w);
        return (w > nlej_pkg::t_cfg'(nlej_pkg::IN_COLS)) ?
               nlej_pkg::t_cfg'(nlej_pkg::IN_COLS) : w;
    endfunction

    // Key column of a row; a key index past the row reads as zero.
    function automatic nlej_pkg::t_col key_sel(input nlej_pkg::t_row row,
                                               input nlej_pkg::t_cfg k);
        nlej_pkg::t_col res;
        res = '0;
        for (int j = 0; j < nlej_pkg::IN_COLS; j++) begin
            if (k == nlej_pkg::t_cfg'(j)) begin
                res = row[j];
            end
        end
        return res;
    endfunction

    // Probe columns, then stored-row columns, then zeros.
    function automatic nlej_pkg::t_out_row join_row(input nlej_pkg::t_row probe,
                                                    input nlej_pkg::t_row inner,
                                                    input nlej_pkg::t_cfg ow,
                                                    input nlej_pkg::t_cfg iw);
        nlej_pkg::t_out_row res;
        res = '0;
        for (int c = 0; c < nlej_pkg::OUT_COLS; c++) begin
            if (c < nlej_pkg::MAX_COLS) begin
                if (c < nlej_pkg::IN_COLS && c < int'(ow)) begin
                    res[c] = probe[c];
                end else begin
                    for (int j = 0; j < nlej_pkg::IN_COLS; j++) begin
                        if (int'(ow) + j == c && j < int'(iw)) begin
                            res[c] = inner[j];
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    // Configuration registers.
    nlej_pkg::t_cfg r_outer_width, r_inner_width, r_outer_key, r_inner_key;

    // Control state.
    t_state             r_state, n_state;
    nlej_pkg::t_row_cnt r_count, n_count;
    logic               r_ovf_seen, n_ovf_seen;
    nlej_pkg::t_row_cnt r_rd_idx, n_rd_idx;
    logic               r_cv, n_cv;
    logic               r_pend_v, n_pend_v;
    logic               r_ov, n_ov;

    // Payload registers.
    nlej_pkg::t_row     r_probe, n_probe;
    nlej_pkg::t_col     r_pkey, n_pkey;
    nlej_pkg::t_row     r_pend_row, n_pend_row;
    nlej_pkg::t_out_row r_out_row, n_out_row;
    logic               r_out_last, n_out_last;
    logic               r_out_flag, n_out_flag;

    nlej_pkg::t_store_req store_req;
    nlej_pkg::t_row       in_row;
    nlej_pkg::t_row       rd_row;
    nlej_pkg::t_cmd       in_cmd;
    nlej_pkg::t_cfg       ow, iw;
    logic                 in_acc, out_free, match, stall, adv;
    logic                 out_load, out_last, out_flag;
    nlej_pkg::t_out_row   out_row;

    assign in_row   = s_axis_tdata;
    assign in_cmd   = nlej_pkg::t_cmd'(s_axis_tuser);
    assign ow       = eff_width(r_outer_width);
    assign iw       = eff_width(r_inner_width);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ov || m_axis_tready;

    // Compare stage: a match with an older match still pending needs the
    // output register, and waits for it.
    assign match = (key_sel(rd_row, r_inner_key) == r_pkey);
    assign stall = r_cv && match && r_pend_v && !out_free;
    assign adv   = !stall;

    nlej_row_store u_store (
        .i_clk    (i_clk),
        .i_req    (store_req),
        .i_wr_row (in_row),
        .o_rd_row (rd_row)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer_width <= nlej_pkg::t_cfg'(1);
            r_inner_width <= nlej_pkg::t_cfg'(1);
            r_outer_key   <= '0;
            r_inner_key   <= '0;
        end else if (i_cfg_we) begin
            unique case (nlej_pkg::t_cfg_idx'(i_cfg_idx))
                nlej_pkg::CFG_OUTER_WIDTH: r_outer_width <= i_cfg_data;
                nlej_pkg::CFG_INNER_WIDTH: r_inner_width <= i_cfg_data;
                nlej_pkg::CFG_OUTER_KEY:   r_outer_key   <= i_cfg_data;
                nlej_pkg::CFG_INNER_KEY:   r_inner_key   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and next-state logic.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ovf_seen = r_ovf_seen;
        n_rd_idx   = r_rd_idx;
        n_cv       = r_cv;
        n_pend_v   = r_pend_v;
        n_probe    = r_probe;
        n_pkey     = r_pkey;
        n_pend_row = r_pend_row;
        store_req  = '0;
        out_load   = 1'b0;
        out_last   = 1'b0;
        out_flag   = 1'b0;
        out_row    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (in_cmd)
                        nlej_pkg::CMD_LOAD: begin
                            if (r_count < nlej_pkg::t_row_cnt'(nlej_pkg::MAX_ROWS)) begin
                                store_req.wr_en   = 1'b1;
                                store_req.wr_addr = r_count[nlej_pkg::ROW_IDX_W-1:0];
                                n_count           = r_count + 1'b1;
                            end else begin
                                n_ovf_seen = 1'b1;
                                n_state    = S_OVF;
                            end
                        end
                        nlej_pkg::CMD_PROBE: begin
                            n_probe  = in_row;
                            n_pkey   = key_sel(in_row, r_outer_key);
                            n_rd_idx = '0;
                            n_cv     = 1'b0;
                            n_pend_v = 1'b0;
                            n_state  = S_SCAN;
                        end
                        nlej_pkg::CMD_CLEAR: begin
                            n_count    = '0;
                            n_ovf_seen = 1'b0;
                        end
                        nlej_pkg::CMD_NOP: ;
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                // Retire the row in the compare stage.
                if (r_cv && adv && match) begin
                    n_pend_row = rd_row;
                    n_pend_v   = 1'b1;
                    if (r_pend_v) begin
                        out_load = 1'b1;
                        out_row  = join_row(r_probe, r_pend_row, ow, iw);
                        out_flag = r_ovf_seen;
                    end
                end
                // Issue the next read when the compare stage moves on.
                if (adv) begin
                    if (r_rd_idx < r_count) begin
                        store_req.rd_en   = 1'b1;
                        store_req.rd_addr = r_rd_idx[nlej_pkg::ROW_IDX_W-1:0];
                        n_rd_idx          = r_rd_idx + 1'b1;
                        n_cv              = 1'b1;
                    end else begin
                        n_cv = 1'b0;
                    end
                end
                if (!r_cv && r_rd_idx == r_count) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // The pending match is the last one of this probe.
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    out_load = 1'b1;
                    out_row  = join_row(r_probe, r_pend_row, ow, iw);
                    out_last = 1'b1;
                    out_flag = r_ovf_seen;
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            S_OVF: begin
                // Dropped load: an all-zero row flagged as overflow.
                if (out_free) begin
                    out_load = 1'b1;
                    out_flag = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb begin
        n_ov       = r_ov;
        n_out_row  = r_out_row;
        n_out_last = r_out_last;
        n_out_flag = r_out_flag;
        if (out_load) begin
            n_ov       = 1'b1;
            n_out_row  = out_row;
            n_out_last = out_last;
            n_out_flag = out_flag;
        end else if (m_axis_tready) begin
            n_ov = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_ovf_seen <= 1'b0;
            r_rd_idx   <= '0;
            r_cv       <= 1'b0;
            r_pend_v   <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_ovf_seen <= n_ovf_seen;
            r_rd_idx   <= n_rd_idx;
            r_cv       <= n_cv;
            r_pend_v   <= n_pend_v;
            r_ov       <= n_ov;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_probe    <= n_probe;
        r_pkey     <= n_pkey;
        r_pend_row <= n_pend_row;
        r_out_row  <= n_out_row;
        r_out_last <= n_out_last;
        r_out_flag <= n_out_flag;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out_row;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_flag;

endmodule

// ----- hdl/nlej_checker.sv -----
// Port-level checks for the nested-loop equi-join unit, and the bind that
// attaches them to the top level. Depends on nlej_pkg.
module nlej_checker (
    input logic                                      i_clk,
    input logic                                      i_rst_n,
    input logic                                      s_axis_tvalid,
    input logic                                      s_axis_tready,
    input logic [1:0]                                s_axis_tuser,
    input logic                                      m_axis_tvalid,
    input logic                                      m_axis_tready,
    input logic [nlej_pkg::OUT_COLS*nlej_pkg::COL_W-1:0] m_axis_tdata
);

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Reset leaves the block idle with no result waiting.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready && !m_axis_tvalid)
        else $error("block not idle after reset");

    // A probe always closes the input right after it is taken.
    a_probe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && s_axis_tuser == nlej_pkg::CMD_PROBE |=> !s_axis_tready)
        else $error("input still open right after a probe");

    // Clear and no-op items finish in the cycle they are taken.
    a_clear_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (s_axis_tuser == nlej_pkg::CMD_CLEAR ||
                   s_axis_tuser == nlej_pkg::CMD_NOP) |=> s_axis_tready)
        else $error("clear or no-op item held the input");

    // A result that is not taken stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind nested_loop_equi_join_unit nlej_checker u_nlej_checker (.*);
